// ----- hdl/v4alu_pkg.sv -----
// Shared types, action codes and constants of the four-component vector ALU.
package v4alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STAGES   = 32;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_SCALE = 3'd3,
        ACT_NORM  = 3'd4,
        ACT_DOT   = 3'd5,
        ACT_CROSS = 3'd6
    } action_t;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
        logic signed [31:0] scalar;
    } in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_w;
        logic signed [31:0] dot_value;
        logic               zero_length;
        logic               saturated;
    } out_t;

    typedef struct packed {
        out_t             res;
        logic             is_norm;
        logic [3:0]       neg;
        logic [3:0][30:0] mag;
    } side_t;

endpackage

// ----- hdl/v4alu_front.sv -----
// Front pipeline: normalise prescale, operand selection, products, sums and saturation.
module v4alu_front #(
    parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  v4alu_pkg::in_t     in_data,
    output logic               out_valid,
    output logic [63:0]        out_sumsq,
    output v4alu_pkg::side_t   out_side
);

    function automatic logic [32:0] mag33(input logic signed [31:0] v);
        logic signed [32:0] e;
        e = 33'(v);
        return e[32] ? 33'(-e) : 33'(e);
    endfunction

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Stage 1: input register and largest magnitude of b.
    logic                 v1_reg;
    v4alu_pkg::in_t       in1_reg;
    logic [32:0]          m1_reg;
    logic [32:0]          m1_next;
    logic [32:0]          mb [4];

    always_comb begin
        mb[0] = mag33(in_data.b_x);
        mb[1] = mag33(in_data.b_y);
        mb[2] = mag33(in_data.b_z);
        mb[3] = mag33(in_data.b_w);
        m1_next = mb[0];
        for (int i = 1; i < 4; i++) begin
            if (mb[i] > m1_next) begin
                m1_next = mb[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in1_reg <= in_data;
            m1_reg  <= m1_next;
        end
    end

    // Stage 2: prescale b and select multiplier operands.
    logic                 v2_reg;
    v4alu_pkg::in_t       in2_reg;
    logic                 zl2_reg;
    logic signed [31:0]   nb2_reg [4];
    logic signed [31:0]   x2_reg [6];
    logic signed [31:0]   y2_reg [6];
    logic signed [31:0]   bv [4];
    logic signed [31:0]   nb [4];
    logic signed [31:0]   x2_next [6];
    logic signed [31:0]   y2_next [6];
    logic [4:0]           top_bit;
    logic [4:0]           sh;
    logic                 big;

    always_comb begin
        bv[0] = in1_reg.b_x;
        bv[1] = in1_reg.b_y;
        bv[2] = in1_reg.b_z;
        bv[3] = in1_reg.b_w;
        big = m1_reg > 33'h0_4000_0000;
        top_bit = '0;
        for (int k = 0; k < 31; k++) begin
            if (m1_reg[k]) begin
                top_bit = 5'(k);
            end
        end
        sh = (top_bit < 5'd29) ? 5'd29 - top_bit : 5'd0;
        for (int i = 0; i < 4; i++) begin
            nb[i] = big ? (bv[i] >>> 1) : (bv[i] <<< sh);
        end
        for (int i = 0; i < 6; i++) begin
            x2_next[i] = '0;
            y2_next[i] = '0;
        end
        case (v4alu_pkg::action_t'(in1_reg.action))
            v4alu_pkg::ACT_MUL, v4alu_pkg::ACT_DOT: begin
                x2_next[0] = in1_reg.a_x; y2_next[0] = in1_reg.b_x;
                x2_next[1] = in1_reg.a_y; y2_next[1] = in1_reg.b_y;
                x2_next[2] = in1_reg.a_z; y2_next[2] = in1_reg.b_z;
                x2_next[3] = in1_reg.a_w; y2_next[3] = in1_reg.b_w;
            end
            v4alu_pkg::ACT_SCALE: begin
                x2_next[0] = in1_reg.a_x; y2_next[0] = in1_reg.scalar;
                x2_next[1] = in1_reg.a_y; y2_next[1] = in1_reg.scalar;
                x2_next[2] = in1_reg.a_z; y2_next[2] = in1_reg.scalar;
            end
            v4alu_pkg::ACT_CROSS: begin
                x2_next[0] = in1_reg.a_y; y2_next[0] = in1_reg.b_z;
                x2_next[1] = in1_reg.a_z; y2_next[1] = in1_reg.b_y;
                x2_next[2] = in1_reg.a_z; y2_next[2] = in1_reg.b_x;
                x2_next[3] = in1_reg.a_x; y2_next[3] = in1_reg.b_z;
                x2_next[4] = in1_reg.a_x; y2_next[4] = in1_reg.b_y;
                x2_next[5] = in1_reg.a_y; y2_next[5] = in1_reg.b_x;
            end
            v4alu_pkg::ACT_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    x2_next[i] = nb[i];
                    y2_next[i] = nb[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in2_reg <= in1_reg;
            zl2_reg <= (m1_reg == '0);
            nb2_reg <= nb;
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
        end
    end

    // Stage 3: products.
    logic                 v3_reg;
    v4alu_pkg::in_t       in3_reg;
    logic                 zl3_reg;
    logic signed [31:0]   nb3_reg [4];
    logic signed [63:0]   p3_reg [6];
    logic signed [63:0]   p3_next [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            p3_next[i] = 64'(x2_reg[i]) * 64'(y2_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in3_reg <= in2_reg;
            zl3_reg <= zl2_reg;
            nb3_reg <= nb2_reg;
            p3_reg  <= p3_next;
        end
    end

    // Stage 4: truncate products and form the unsaturated sums.
    logic                 v4_reg;
    logic [2:0]           act4_reg;
    logic                 zl4_reg;
    logic signed [31:0]   nb4_reg [4];
    logic signed [63:0]   pre4_reg [3];
    logic signed [63:0]   dot4_reg;
    logic [63:0]          sum4_reg;
    logic signed [63:0]   t [6];
    logic signed [63:0]   ae [3];
    logic signed [63:0]   be [3];
    logic signed [63:0]   pre4_next [3];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            t[i] = p3_reg[i] >>> FRAC_BITS;
        end
        ae[0] = 64'(in3_reg.a_x);
        ae[1] = 64'(in3_reg.a_y);
        ae[2] = 64'(in3_reg.a_z);
        be[0] = 64'(in3_reg.b_x);
        be[1] = 64'(in3_reg.b_y);
        be[2] = 64'(in3_reg.b_z);
        for (int i = 0; i < 3; i++) begin
            pre4_next[i] = t[i];
        end
        case (v4alu_pkg::action_t'(in3_reg.action))
            v4alu_pkg::ACT_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    pre4_next[i] = ae[i] + be[i];
                end
            end
            v4alu_pkg::ACT_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    pre4_next[i] = ae[i] - be[i];
                end
            end
            v4alu_pkg::ACT_CROSS: begin
                pre4_next[0] = t[0] - t[1];
                pre4_next[1] = t[2] - t[3];
                pre4_next[2] = t[4] - t[5];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act4_reg <= in3_reg.action;
            zl4_reg  <= zl3_reg;
            nb4_reg  <= nb3_reg;
            pre4_reg <= pre4_next;
            dot4_reg <= t[0] + t[1] + t[2] + t[3];
            sum4_reg <= 64'(p3_reg[0] + p3_reg[1] + p3_reg[2] + p3_reg[3]);
        end
    end

    // Stage 5: saturation and result assembly.
    logic                 v5_reg;
    logic [63:0]          sum5_reg;
    v4alu_pkg::side_t     side5_reg;
    v4alu_pkg::side_t     side5_next;
    logic [32:0]          sx;
    logic [32:0]          sy;
    logic [32:0]          sz;
    logic [32:0]          sd;
    logic [32:0]          nm;

    always_comb begin
        sx = sat32(pre4_reg[0]);
        sy = sat32(pre4_reg[1]);
        sz = sat32(pre4_reg[2]);
        sd = sat32(dot4_reg);
        side5_next = '0;
        for (int i = 0; i < 4; i++) begin
            nm = mag33(nb4_reg[i]);
            side5_next.neg[i] = nb4_reg[i][31];
            side5_next.mag[i] = nm[30:0];
        end
        case (v4alu_pkg::action_t'(act4_reg))
            v4alu_pkg::ACT_ADD, v4alu_pkg::ACT_SUB, v4alu_pkg::ACT_MUL,
            v4alu_pkg::ACT_SCALE, v4alu_pkg::ACT_CROSS: begin
                side5_next.res.r_x       = sx[31:0];
                side5_next.res.r_y       = sy[31:0];
                side5_next.res.r_z       = sz[31:0];
                side5_next.res.r_w       = 32'(1) << FRAC_BITS;
                side5_next.res.saturated = sx[32] | sy[32] | sz[32];
            end
            v4alu_pkg::ACT_DOT: begin
                side5_next.res.dot_value = sd[31:0];
                side5_next.res.saturated = sd[32];
            end
            v4alu_pkg::ACT_NORM: begin
                side5_next.is_norm         = 1'b1;
                side5_next.res.zero_length = zl4_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum5_reg  <= sum4_reg;
            side5_reg <= side5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_sumsq = sum5_reg;
    assign out_side  = side5_reg;

endmodule

// ----- hdl/v4alu_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module v4alu_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        in_n,
    input  v4alu_pkg::side_t   in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output v4alu_pkg::side_t   out_side
);

    localparam int STAGES = v4alu_pkg::SQRT_STAGES;

    logic               v_reg    [STAGES];
    logic [63:0]        n_reg    [STAGES];
    logic [63:0]        r_reg    [STAGES];
    v4alu_pkg::side_t   side_reg [STAGES];
    logic               src_v    [STAGES];
    logic [63:0]        src_n    [STAGES];
    logic [63:0]        src_r    [STAGES];
    v4alu_pkg::side_t   src_side [STAGES];

    always_comb begin
        src_v[0]    = in_valid;
        src_n[0]    = in_n;
        src_r[0]    = '0;
        src_side[0] = in_side;
        for (int g = 1; g < STAGES; g++) begin
            src_v[g]    = v_reg[g-1];
            src_n[g]    = n_reg[g-1];
            src_r[g]    = r_reg[g-1];
            src_side[g] = side_reg[g-1];
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int SH = 62 - 2 * g;
        logic [63:0] trial;
        logic [63:0] n_next;
        logic [63:0] r_next;

        always_comb begin
            trial = src_r[g] + (64'(1) << SH);
            if (src_n[g] >= trial) begin
                n_next = src_n[g] - trial;
                r_next = (src_r[g] >> 1) + (64'(1) << SH);
            end else begin
                n_next = src_n[g];
                r_next = src_r[g] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= src_v[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[g]    <= n_next;
                r_reg[g]    <= r_next;
                side_reg[g] <= src_side[g];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = r_reg[STAGES-1][31:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- hdl/v4alu_div.sv -----
// Pipelined four-lane restoring divider for the normalise quotients.
module v4alu_div #(
    parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        in_len,
    input  v4alu_pkg::side_t   in_side,
    output logic               out_valid,
    output logic [3:0][31:0]   out_quot,
    output v4alu_pkg::side_t   out_side
);

    localparam int STAGES = FRAC_BITS + 1;

    logic               v_reg    [STAGES];
    logic [31:0]        d_reg    [STAGES];
    logic [3:0][63:0]   rem_reg  [STAGES];
    logic [3:0][31:0]   q_reg    [STAGES];
    v4alu_pkg::side_t   side_reg [STAGES];
    logic               src_v    [STAGES];
    logic [31:0]        src_d    [STAGES];
    logic [3:0][63:0]   src_rem  [STAGES];
    logic [3:0][31:0]   src_q    [STAGES];
    v4alu_pkg::side_t   src_side [STAGES];

    always_comb begin
        src_v[0]    = in_valid;
        src_d[0]    = (in_len == '0) ? 32'd1 : in_len;
        src_q[0]    = '0;
        src_side[0] = in_side;
        for (int i = 0; i < 4; i++) begin
            src_rem[0][i] = 64'(in_side.mag[i]) << FRAC_BITS;
        end
        for (int g = 1; g < STAGES; g++) begin
            src_v[g]    = v_reg[g-1];
            src_d[g]    = d_reg[g-1];
            src_rem[g]  = rem_reg[g-1];
            src_q[g]    = q_reg[g-1];
            src_side[g] = side_reg[g-1];
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int J = FRAC_BITS - g;
        logic [63:0]      trial;
        logic [3:0][63:0] rem_next;
        logic [3:0][31:0] q_next;

        always_comb begin
            trial = 64'(src_d[g]) << J;
            for (int i = 0; i < 4; i++) begin
                if (src_rem[g][i] >= trial) begin
                    rem_next[i] = src_rem[g][i] - trial;
                    q_next[i]   = src_q[g][i] | (32'(1) << J);
                end else begin
                    rem_next[i] = src_rem[g][i];
                    q_next[i]   = src_q[g][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= src_v[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[g]    <= src_d[g];
                rem_reg[g]  <= rem_next;
                q_reg[g]    <= q_next;
                side_reg[g] <= src_side[g];
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_quot  = q_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- hdl/vec4_vector_alu.sv -----
// Top level of the four-component Q16.16 vector ALU.
// Takes one beat per cycle and returns one result beat per input beat, in order, through
// five front stages for prescale, products and saturation, thirty-two square-root stages,
// FRAC_BITS + 1 divider stages for the normalise quotients and one output register. Every
// action takes that same path, so the latency does not depend on the action. The whole
// pipeline holds while a result waits.
module vec4_vector_alu #(
    parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  v4alu_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output v4alu_pkg::out_t   m_data
);

    logic               adv;
    logic               fr_valid;
    logic [63:0]        fr_sumsq;
    v4alu_pkg::side_t   fr_side;
    logic               sq_valid;
    logic [31:0]        sq_root;
    v4alu_pkg::side_t   sq_side;
    logic               dv_valid;
    logic [3:0][31:0]   dv_quot;
    v4alu_pkg::side_t   dv_side;
    logic               out_valid_reg;
    v4alu_pkg::out_t    out_data_reg;
    v4alu_pkg::out_t    out_data_next;
    logic [3:0][31:0]   nq;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    v4alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_sumsq (fr_sumsq),
        .out_side  (fr_side)
    );

    v4alu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (fr_valid),
        .in_n      (fr_sumsq),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    v4alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nq[i] = dv_side.neg[i] ? -dv_quot[i] : dv_quot[i];
        end
        out_data_next = dv_side.res;
        if (dv_side.is_norm) begin
            out_data_next.r_x = nq[0];
            out_data_next.r_y = nq[1];
            out_data_next.r_z = nq[2];
            out_data_next.r_w = nq[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the four-component vector ALU with a built-in result predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = v4alu_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = FB + 39;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    v4alu_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    v4alu_pkg::out_t m_data;

    v4alu_pkg::out_t expected_q[$];
    int errors = 0;
    longint cycles = 0;

    vec4_vector_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic longint fx_mul(longint x, longint y);
        return (x * y) >>> FB;
    endfunction

    function automatic longint clip32(longint v, ref logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic v4alu_pkg::out_t predict_vector(v4alu_pkg::in_t it);
        longint a[4], b[4], r[4], s, acc, m, sum, len;
        logic clip;
        v4alu_pkg::out_t o;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z; a[3] = it.a_w;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z; b[3] = it.b_w;
        s = it.scalar;
        r = '{0, 0, 0, 0};
        clip = 1'b0;
        o = '0;
        case (it.action)
            v4alu_pkg::ACT_ADD: begin
                for (int i = 0; i < 3; i++) r[i] = clip32(a[i] + b[i], clip);
                r[3] = 1 << FB;
            end
            v4alu_pkg::ACT_SUB: begin
                for (int i = 0; i < 3; i++) r[i] = clip32(a[i] - b[i], clip);
                r[3] = 1 << FB;
            end
            v4alu_pkg::ACT_MUL: begin
                for (int i = 0; i < 3; i++) r[i] = clip32(fx_mul(a[i], b[i]), clip);
                r[3] = 1 << FB;
            end
            v4alu_pkg::ACT_SCALE: begin
                for (int i = 0; i < 3; i++) r[i] = clip32(fx_mul(a[i], s), clip);
                r[3] = 1 << FB;
            end
            v4alu_pkg::ACT_NORM: begin
                m = 0;
                for (int i = 0; i < 4; i++) if ((b[i] < 0 ? -b[i] : b[i]) > m)
                    m = b[i] < 0 ? -b[i] : b[i];
                if (m == 0) begin
                    o.zero_length = 1'b1;
                end else begin
                    if (m > (64'sd1 << 30)) begin
                        for (int i = 0; i < 4; i++) b[i] = b[i] >>> 1;
                    end else begin
                        while (m < (64'sd1 << 29)) begin
                            m = m << 1;
                            for (int i = 0; i < 4; i++) b[i] = b[i] * 2;
                        end
                    end
                    sum = 0;
                    for (int i = 0; i < 4; i++) sum += b[i] * b[i];
                    len = floor_sqrt(sum);
                    if (len == 0) len = 1;
                    for (int i = 0; i < 4; i++) r[i] = (b[i] * (64'sd1 << FB)) / len;
                end
            end
            v4alu_pkg::ACT_DOT: begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += fx_mul(a[i], b[i]);
                o.dot_value = 32'(clip32(acc, clip));
            end
            v4alu_pkg::ACT_CROSS: begin
                r[0] = clip32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), clip);
                r[1] = clip32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), clip);
                r[2] = clip32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), clip);
                r[3] = 1 << FB;
            end
            default: ;
        endcase
        o.r_x = 32'(r[0]); o.r_y = 32'(r[1]); o.r_z = 32'(r[2]); o.r_w = 32'(r[3]);
        o.saturated = clip;
        return o;
    endfunction

    task automatic send_beat(v4alu_pkg::in_t it);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_vector(it));
        @(negedge aclk);
    endtask

    // Receiver: random stall before each beat, with bursts of no stalling.
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        v4alu_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (want.r_x !== m_data.r_x)
                    $display("%0t: r_x exp %h got %h", $time, want.r_x, m_data.r_x);
                if (want.r_y !== m_data.r_y)
                    $display("%0t: r_y exp %h got %h", $time, want.r_y, m_data.r_y);
                if (want.r_z !== m_data.r_z)
                    $display("%0t: r_z exp %h got %h", $time, want.r_z, m_data.r_z);
                if (want.r_w !== m_data.r_w)
                    $display("%0t: r_w exp %h got %h", $time, want.r_w, m_data.r_w);
                if (want.dot_value !== m_data.dot_value)
                    $display("%0t: dot_value exp %h got %h", $time, want.dot_value,
                             m_data.dot_value);
                if (want.zero_length !== m_data.zero_length)
                    $display("%0t: zero_length exp %b got %b", $time, want.zero_length,
                             m_data.zero_length);
                if (want.saturated !== m_data.saturated)
                    $display("%0t: saturated exp %b got %b", $time, want.saturated,
                             m_data.saturated);
                if (want !== m_data) errors++;
            end
        end
    end

    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'($signed($urandom_range(0, 255)) - 128);
            4: return 32'h0;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic v4alu_pkg::in_t rand_item(logic [2:0] act);
        v4alu_pkg::in_t it;
        it.action = act;
        it.a_x = rand_component(); it.a_y = rand_component();
        it.a_z = rand_component(); it.a_w = rand_component();
        it.b_x = rand_component(); it.b_y = rand_component();
        it.b_z = rand_component(); it.b_w = rand_component();
        it.scalar = rand_component();
        return it;
    endfunction

    task automatic test_extremes();
        v4alu_pkg::in_t it;
        for (int act = 0; act < 8; act++) begin
            it = '{action: 3'(act), a_x: 32'h7fffffff, a_y: 32'h80000000, a_z: 32'h7fffffff,
                   a_w: 32'h80000000, b_x: 32'h7fffffff, b_y: 32'h7fffffff,
                   b_z: 32'h80000000, b_w: 32'h80000000, scalar: 32'h80000000};
            send_beat(it);
            send_beat('{action: 3'(act), default: 32'h0});
        end
    endtask

    task automatic test_normalize_cases();
        send_beat('{action: v4alu_pkg::ACT_NORM, b_x: 32'h1, default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_NORM, b_w: 32'hffffffff, default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_NORM, b_x: 32'h40000001, b_y: 32'hc0000000,
                    default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_NORM, b_x: 32'h40000000, b_z: 32'h20000000,
                    default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_NORM, b_x: 32'h00010000, b_y: 32'h00010000,
                    b_z: 32'h00010000, b_w: 32'h00010000, default: 32'h0});
    endtask

    task automatic test_cross_unit_axes();
        send_beat('{action: v4alu_pkg::ACT_CROSS, a_x: 32'h00010000, b_y: 32'h00010000,
                    default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_CROSS, a_z: 32'h00010000, b_x: 32'h00010000,
                    default: 32'h0});
        send_beat('{action: v4alu_pkg::ACT_CROSS, a_y: 32'hffff0000, b_z: 32'h00030000,
                    default: 32'h0});
    endtask

    task automatic test_random_items(int count);
        for (int n = 0; n < count; n++)
            send_beat(rand_item($urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6))));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_normalize_cases();
        test_cross_unit_axes();
        test_random_items(1425);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
